@@ rtl/ppd_pkg.sv @@
// ----------------------------------------------------------------------------
// Point-to-polyline distance package
// Shared widths, types and the shared multiplier function.
// ----------------------------------------------------------------------------
`default_nettype none
package ppd_pkg;
    localparam int CoordW = 24;             // vertex and query coordinate width
    localparam int DiffW  = CoordW + 1;     // coordinate difference
    localparam int MulW   = DiffW + 1;      // multiplier operand (signed)
    localparam int ProdW  = 2 * MulW;       // multiplier product and sums
    localparam int SqW    = 50;             // squared distance result
    localparam int HalfW  = SqW / 2;        // half of the cross magnitude
    localparam int NumW   = 2 * SqW;        // squared cross product
    localparam int CntW   = $clog2(NumW);
    localparam int FifoDepth = 2;
    localparam int PtrW   = $clog2(FifoDepth);
    localparam int FillW  = $clog2(FifoDepth + 1);
    localparam int AddrW  = 3;

    localparam logic [SqW-1:0] SqMax = {SqW{1'b1}};

    typedef logic signed [CoordW-1:0] t_coord;

    typedef struct packed {
        t_coord x;
        t_coord y;
        logic   last;
        logic   first;
    } t_vtx;

    typedef struct packed {
        t_coord qx;
        t_coord qy;
    } t_query;

    function automatic logic signed [ProdW-1:0] mul_s(
        input logic signed [MulW-1:0] a,
        input logic signed [MulW-1:0] b
    );
        mul_s = a * b;
    endfunction
endpackage
`default_nettype wire

@@ rtl/ppd_cfg.sv @@
// ----------------------------------------------------------------------------
// Query point registers
// APB-style register file holding the query point coordinates.
// ----------------------------------------------------------------------------
`default_nettype none
module ppd_cfg import ppd_pkg::*; (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_psel,
    input  wire logic             i_penable,
    input  wire logic             i_pwrite,
    input  wire logic [AddrW-1:0] i_paddr,
    input  wire logic [31:0]      i_pwdata,
    output logic      [31:0]      o_prdata,
    output t_query                o_query
);
    t_query r_query;
    logic   wr;

    assign wr = i_psel && i_penable && i_pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_query <= '0;
        end else if (wr) begin
            if (i_paddr[2]) r_query.qy <= i_pwdata[CoordW-1:0];
            else            r_query.qx <= i_pwdata[CoordW-1:0];
        end
    end

    always_comb begin
        if (i_paddr[2]) o_prdata = 32'(r_query.qy);
        else            o_prdata = 32'(r_query.qx);
    end

    assign o_query = r_query;
endmodule
`default_nettype wire

@@ rtl/ppd_front.sv @@
// ----------------------------------------------------------------------------
// Vertex front end
// Accepts vertices and marks the first vertex of each polyline.
// ----------------------------------------------------------------------------
`default_nettype none
module ppd_front import ppd_pkg::*; (
    input  wire logic   i_clk,
    input  wire logic   i_rst_n,
    input  wire logic   i_valid,
    input  wire t_coord i_point_x,
    input  wire t_coord i_point_y,
    input  wire logic   i_is_last,
    input  wire logic   i_full,
    output logic        o_stall,
    output logic        o_push,
    output t_vtx        o_vtx
);
    logic r_mid_line;

    assign o_stall = i_full;
    assign o_push  = i_valid && !i_full;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mid_line <= 1'b0;
        end else if (o_push) begin
            r_mid_line <= !i_is_last;
        end
    end

    always_comb begin
        o_vtx.x     = i_point_x;
        o_vtx.y     = i_point_y;
        o_vtx.last  = i_is_last;
        o_vtx.first = !r_mid_line;
    end
endmodule
`default_nettype wire

@@ rtl/ppd_fifo.sv @@
// ----------------------------------------------------------------------------
// Vertex queue
// Short queue between the front end and the segment engine.
// ----------------------------------------------------------------------------
`default_nettype none
module ppd_fifo import ppd_pkg::*; (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_push,
    input  wire t_vtx i_vtx,
    input  wire logic i_pop,
    output logic      o_full,
    output logic      o_empty,
    output t_vtx      o_vtx
);
    t_vtx             r_mem [FifoDepth];
    logic [PtrW-1:0]  r_wptr, r_rptr;
    logic [FillW-1:0] r_fill;

    always_ff @(posedge i_clk) begin
        if (i_push) r_mem[r_wptr] <= i_vtx;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr <= '0;
            r_rptr <= '0;
            r_fill <= '0;
        end else begin
            if (i_push) r_wptr <= r_wptr + 1'b1;
            if (i_pop)  r_rptr <= r_rptr + 1'b1;
            if (i_push && !i_pop)      r_fill <= r_fill + 1'b1;
            else if (!i_push && i_pop) r_fill <= r_fill - 1'b1;
        end
    end

    assign o_full  = (r_fill == FillW'(FifoDepth));
    assign o_empty = (r_fill == '0);
    assign o_vtx   = r_mem[r_rptr];
endmodule
`default_nettype wire

@@ rtl/ppd_back.sv @@
// ----------------------------------------------------------------------------
// Segment engine
// Sequences one shared multiplier and a bit-serial divider per segment.
// ----------------------------------------------------------------------------
`default_nettype none
module ppd_back import ppd_pkg::*; (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire t_query         i_query,
    input  wire logic           i_empty,
    input  wire t_vtx           i_vtx,
    output logic                o_pop,
    output logic                o_valid,
    input  wire logic           i_stall,
    output logic [SqW-1:0]      o_min_sq_distance
);
    localparam logic [4:0] S_IDLE = 5'd0,  S_L0 = 5'd1,  S_L1 = 5'd2,  S_L2 = 5'd3,
                           S_L3   = 5'd4,  S_L4 = 5'd5,  S_L5 = 5'd6,  S_L6 = 5'd7,
                           S_L7   = 5'd8,  S_L8 = 5'd9,  S_DEC = 5'd10, S_Q0 = 5'd11,
                           S_Q1   = 5'd12, S_Q2 = 5'd13, S_Q3 = 5'd14, S_DIV = 5'd15,
                           S_QS   = 5'd16, S_FIN = 5'd17;

    logic [4:0]              r_state;
    t_coord                  r_ax, r_ay, r_bx, r_by;
    logic                    r_first, r_last;
    logic signed [ProdW-1:0] r_p, r_len, r_e, r_dot, r_cr;
    logic [SqW-1:0]          r_c, r_cand, r_best, r_rem;
    logic                    r_use;
    logic [NumW-1:0]         r_num;
    logic [CntW-1:0]         r_cnt;
    logic                    r_ovalid;
    logic [SqW-1:0]          r_odata;

    logic signed [DiffW-1:0] dabx, daby, daqx, daqy, dbqx, dbqy;
    logic signed [MulW-1:0]  op_a, op_b;
    logic signed [ProdW-1:0] cr_abs;
    logic [HalfW-1:0]        c_hi, c_lo;
    logic [NumW-1:0]         p_ext;
    logic [SqW:0]            div_sh;
    logic                    div_ge;
    logic [SqW-1:0]          n_best;
    logic                    fin_hold;
    logic                    fin_out;

    always_comb begin
        dabx = DiffW'(r_ax) - DiffW'(r_bx);
        daby = DiffW'(r_ay) - DiffW'(r_by);
        daqx = DiffW'(r_ax) - DiffW'(i_query.qx);
        daqy = DiffW'(r_ay) - DiffW'(i_query.qy);
        dbqx = DiffW'(r_bx) - DiffW'(i_query.qx);
        dbqy = DiffW'(r_by) - DiffW'(i_query.qy);
        c_hi = r_c[SqW-1:HalfW];
        c_lo = r_c[HalfW-1:0];
        cr_abs = r_cr[ProdW-1] ? -r_cr : r_cr;
        p_ext = NumW'(r_p[SqW-1:0]);
        div_sh = {r_rem, r_num[NumW-1]};
        div_ge = div_sh >= {1'b0, r_len[SqW-1:0]};
    end

    // operand select for the shared multiplier
    always_comb begin
        case (r_state)
            S_L0:    begin op_a = MulW'(dabx); op_b = MulW'(dabx); end
            S_L1:    begin op_a = MulW'(daby); op_b = MulW'(daby); end
            S_L2:    begin op_a = MulW'(dbqx); op_b = MulW'(dbqx); end
            S_L3:    begin op_a = MulW'(dbqy); op_b = MulW'(dbqy); end
            S_L4:    begin op_a = MulW'(dabx); op_b = MulW'(daqx); end
            S_L5:    begin op_a = MulW'(daby); op_b = MulW'(daqy); end
            S_L6:    begin op_a = MulW'(dabx); op_b = MulW'(dbqy); end
            S_L7:    begin op_a = MulW'(daby); op_b = MulW'(dbqx); end
            S_Q0:    begin op_a = {1'b0, c_hi}; op_b = {1'b0, c_hi}; end
            S_Q1:    begin op_a = {1'b0, c_hi}; op_b = {1'b0, c_lo}; end
            S_Q2:    begin op_a = {1'b0, c_lo}; op_b = {1'b0, c_lo}; end
            default: begin op_a = '0; op_b = '0; end
        endcase
    end

    always_comb begin
        if (r_first)                       n_best = r_cand;
        else if (r_use && r_cand < r_best) n_best = r_cand;
        else                               n_best = r_best;
    end

    assign fin_hold = r_last && r_ovalid && i_stall;
    assign fin_out  = (r_state == S_FIN) && r_last && !fin_hold;
    assign o_pop    = (r_state == S_IDLE) && !i_empty;

    always_ff @(posedge i_clk) begin
        r_p <= mul_s(op_a, op_b);
        case (r_state)
            S_IDLE: begin
                r_bx    <= i_vtx.x;
                r_by    <= i_vtx.y;
                r_first <= i_vtx.first;
                r_last  <= i_vtx.last;
            end
            S_L1: r_len <= r_p;
            S_L2: r_len <= r_len + r_p;
            S_L3: r_e   <= r_p;
            S_L4: r_e   <= r_e + r_p;
            S_L5: r_dot <= r_p;
            S_L6: r_dot <= r_dot + r_p;
            S_L7: r_cr  <= r_p;
            S_L8: r_cr  <= r_cr - r_p;
            S_DEC: begin
                r_c    <= cr_abs[SqW-1:0];
                r_cand <= r_e[SqW-1:0];
                r_use  <= !r_dot[ProdW-1] || r_first || (r_len == '0);
                r_rem  <= '0;
                r_cnt  <= '0;
            end
            S_Q1: r_num <= {p_ext[SqW-1:0], {SqW{1'b0}}};
            S_Q2: r_num <= r_num + (p_ext << (HalfW + 1));
            S_Q3: r_num <= r_num + p_ext;
            S_DIV: begin
                r_rem <= div_ge ? SqW'(div_sh - {1'b0, r_len[SqW-1:0]}) : div_sh[SqW-1:0];
                r_num <= {r_num[NumW-2:0], div_ge};
                r_cnt <= r_cnt + 1'b1;
            end
            S_QS: r_cand <= (|r_num[NumW-1:SqW]) ? SqMax : r_num[SqW-1:0];
            S_FIN: begin
                if (!fin_hold) begin
                    r_ax <= r_bx;
                    r_ay <= r_by;
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_best   <= '0;
            r_ovalid <= 1'b0;
        end else begin
            if (fin_out)                   r_ovalid <= 1'b1;
            else if (r_ovalid && !i_stall) r_ovalid <= 1'b0;
            case (r_state)
                S_IDLE: if (!i_empty) r_state <= S_L0;
                S_L0:   r_state <= S_L1;
                S_L1:   r_state <= S_L2;
                S_L2:   r_state <= S_L3;
                S_L3:   r_state <= S_L4;
                S_L4:   r_state <= S_L5;
                S_L5:   r_state <= S_L6;
                S_L6:   r_state <= S_L7;
                S_L7:   r_state <= S_L8;
                S_L8:   r_state <= S_DEC;
                S_DEC: begin
                    // interior projection needs the divide, all else is settled
                    if (r_first || r_len == '0 || r_dot[ProdW-1] ||
                        (r_dot > r_len)) begin
                        r_state <= S_FIN;
                    end else begin
                        r_state <= S_Q0;
                    end
                end
                S_Q0:   r_state <= S_Q1;
                S_Q1:   r_state <= S_Q2;
                S_Q2:   r_state <= S_Q3;
                S_Q3:   r_state <= S_DIV;
                S_DIV:  if (r_cnt == CntW'(NumW - 1)) r_state <= S_QS;
                S_QS:   r_state <= S_FIN;
                S_FIN: begin
                    if (!fin_hold) begin
                        r_best  <= n_best;
                        r_state <= S_IDLE;
                        if (r_last) r_odata <= n_best;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_valid           = r_ovalid;
    assign o_min_sq_distance = r_odata;
endmodule
`default_nettype wire

@@ rtl/point_polyline_min_distance_top.sv @@
// ----------------------------------------------------------------------------
// Point to polyline minimum squared distance
// Streams polyline vertices and reports the least squared distance to a query.
// ----------------------------------------------------------------------------
// Channel   Direction  Handshake           Payload
// vertex    in         i_valid / o_stall   i_point_x, i_point_y, i_is_last
// result    out        o_valid / i_stall   o_min_sq_distance
// config    in         APB write/read      query_x @0x0, query_y @0x4
//
// A first vertex, a skipped segment or one clamped to its end vertex skips
// the divide; a segment with an interior projection runs the one-bit-per-cycle
// divider over the 100-bit squared cross product.
// Reset clears the query point, the running minimum and the line state.
// A two-entry queue lets vertices arrive while the engine works; a result
// waits in the output register and the engine stalls only on the next last.
`default_nettype none
module point_polyline_min_distance_top import ppd_pkg::*; (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_valid,
    output logic                  o_stall,
    input  wire t_coord           i_point_x,
    input  wire t_coord           i_point_y,
    input  wire logic             i_is_last,
    output logic                  o_valid,
    input  wire logic             i_stall,
    output logic [SqW-1:0]        o_min_sq_distance,
    input  wire logic             i_psel,
    input  wire logic             i_penable,
    input  wire logic             i_pwrite,
    input  wire logic [AddrW-1:0] i_paddr,
    input  wire logic [31:0]      i_pwdata,
    output logic      [31:0]      o_prdata,
    output logic                  o_pready
);
    t_query query;
    t_vtx   push_vtx, pop_vtx;
    logic   push, pop, full, empty;

    assign o_pready = 1'b1;

    ppd_cfg u_cfg (
        .i_clk, .i_rst_n, .i_psel, .i_penable, .i_pwrite, .i_paddr, .i_pwdata,
        .o_prdata, .o_query(query)
    );

    ppd_front u_front (
        .i_clk, .i_rst_n, .i_valid, .i_point_x, .i_point_y, .i_is_last,
        .i_full(full), .o_stall, .o_push(push), .o_vtx(push_vtx)
    );

    ppd_fifo u_fifo (
        .i_clk, .i_rst_n, .i_push(push), .i_vtx(push_vtx), .i_pop(pop),
        .o_full(full), .o_empty(empty), .o_vtx(pop_vtx)
    );

    ppd_back u_back (
        .i_clk, .i_rst_n, .i_query(query), .i_empty(empty), .i_vtx(pop_vtx),
        .o_pop(pop), .o_valid, .i_stall, .o_min_sq_distance
    );
endmodule
`default_nettype wire
